// ===== sv/tcw_pkg.sv =====
// shared types, constants and helpers for the text console writer
package tcw_pkg;

  localparam int COLUMNS    = 80;
  localparam int ROWS       = 25;
  localparam int CELL_COUNT = COLUMNS * ROWS;
  localparam int MOVE_COUNT = COLUMNS * (ROWS - 1);
  localparam int ADDR_W     = $clog2(CELL_COUNT);
  localparam int OUT_LIN_W  = 11;
  localparam int LIN_W      = (ADDR_W > OUT_LIN_W) ? ADDR_W : OUT_LIN_W;
  localparam int COL_W      = 7;
  localparam int ROW_W      = 5;
  localparam int CHAR_W     = 8;
  localparam int COLOR_W    = 4;
  localparam int ATTR_W     = 8;
  localparam int CELL_W     = 16;

  localparam logic [CHAR_W-1:0] CH_NEWLINE   = 8'd10;
  localparam logic [CHAR_W-1:0] CH_RETURN    = 8'd13;
  localparam logic [CHAR_W-1:0] CH_BACKSPACE = 8'd8;
  localparam logic [CHAR_W-1:0] CH_SPACE     = 8'd32;
  localparam logic [ATTR_W-1:0] FILL_ATTR_RESET = 8'd7;

  typedef enum logic [1:0] {
    REQ_PUT,
    REQ_CLEAR,
    REQ_SET,
    REQ_READ
  } tcw_req_t;

  typedef struct packed {
    tcw_req_t             req;
    logic [CHAR_W-1:0]    ch;
    logic [COLOR_W-1:0]   fg;
    logic [COLOR_W-1:0]   bg;
    logic [COL_W-1:0]     tx;
    logic [ROW_W-1:0]     ty;
  } tcw_item_t;

  typedef struct packed {
    logic                 scrolled;
    logic [CELL_W-1:0]    cell_word;
    logic [OUT_LIN_W-1:0] linear;
    logic [ROW_W-1:0]     row;
    logic [COL_W-1:0]     col;
  } tcw_result_t;

  function automatic logic [CELL_W-1:0] make_cell(input logic [CHAR_W-1:0] ch,
                                                  input logic [COLOR_W-1:0] fg,
                                                  input logic [COLOR_W-1:0] bg);
    make_cell = {bg, fg, ch};
  endfunction

endpackage

// ===== sv/tcw_addr_unit.sv =====
// shared address unit: row times columns plus column, registered
module tcw_addr_unit
  import tcw_pkg::*;
(
  input  logic             clk,
  input  logic [ROW_W-1:0] row,
  input  logic [COL_W-1:0] col,
  output logic [LIN_W-1:0] lin
);

  always_ff @(posedge clk) begin
    lin <= LIN_W'(row) * LIN_W'(COLUMNS) + LIN_W'(col);
  end

endmodule

// ===== sv/tcw_engine.sv =====
// request sequencer with cursor state and the cell store
module tcw_engine
  import tcw_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  tcw_item_t         item,
  input  logic [ATTR_W-1:0] fill_attr,
  input  logic              out_free,
  output logic              idle,
  output logic              done,
  output tcw_result_t       result
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_ADDR,
    S_APPLY,
    S_RWAIT,
    S_MOVE,
    S_FILL,
    S_LIN,
    S_DONE
  } state_t;

  state_t            state;
  tcw_item_t         item_q;
  logic [COL_W-1:0]  cur_col;
  logic [ROW_W-1:0]  cur_row;
  logic [ADDR_W-1:0] idx;
  logic [ADDR_W-1:0] ridx;
  logic              pend;
  logic [ADDR_W-1:0] pend_addr;
  logic [CELL_W-1:0] fill_word;
  logic [CELL_W-1:0] cell_q;
  logic              scrolled_q;
  logic [CELL_W-1:0] rdata;
  logic [CELL_W-1:0] mem [CELL_COUNT];

  logic [ROW_W-1:0]  a_row;
  logic [COL_W-1:0]  a_col;
  logic [LIN_W-1:0]  lin;

  logic              is_nl;
  logic              is_cr;
  logic              is_bs;
  logic              put_wr;
  logic [CELL_W-1:0] put_word;
  logic [COL_W-1:0]  col_a;
  logic [ROW_W-1:0]  row_a;
  logic              scroll_n;

  logic              we;
  logic [ADDR_W-1:0] waddr;
  logic [CELL_W-1:0] wdata;
  logic              re;
  logic [ADDR_W-1:0] raddr;

  tcw_addr_unit u_addr (
    .clk (clk),
    .row (a_row),
    .col (a_col),
    .lin (lin)
  );

  assign is_nl = (item_q.ch == CH_NEWLINE);
  assign is_cr = (item_q.ch == CH_RETURN);
  assign is_bs = (item_q.ch == CH_BACKSPACE);
  assign put_wr = is_bs ? (cur_col != '0) : (!is_nl && !is_cr);
  assign put_word = make_cell(is_bs ? CH_SPACE : item_q.ch, item_q.fg, item_q.bg);

  // the cell a request touches, or the final cursor for the linear report
  always_comb begin
    a_row = cur_row;
    a_col = cur_col;
    if (state != S_LIN && state != S_DONE) begin
      if (item_q.req == REQ_READ) begin
        a_row = item_q.ty;
        a_col = item_q.tx;
      end else if (is_bs) begin
        a_col = cur_col - COL_W'(1);
      end
    end
  end

  // cursor motion of a put request, wrap and scroll included
  always_comb begin
    col_a = cur_col;
    row_a = cur_row;
    if (is_nl) begin
      col_a = '0;
      row_a = cur_row + ROW_W'(1);
    end else if (is_cr) begin
      col_a = '0;
    end else if (is_bs) begin
      if (cur_col != '0) begin
        col_a = cur_col - COL_W'(1);
      end
    end else begin
      col_a = cur_col + COL_W'(1);
    end
    if (col_a >= COL_W'(COLUMNS)) begin
      col_a = '0;
      row_a = row_a + ROW_W'(1);
    end
    scroll_n = (row_a >= ROW_W'(ROWS));
    if (scroll_n) begin
      row_a = ROW_W'(ROWS - 1);
    end
  end

  // one write port, one read port; a pending move write wins
  always_comb begin
    we    = 1'b0;
    waddr = lin[ADDR_W-1:0];
    wdata = put_word;
    re    = 1'b0;
    raddr = ridx;
    if (pend) begin
      we    = 1'b1;
      waddr = pend_addr;
      wdata = rdata;
    end else if (state == S_FILL) begin
      we    = 1'b1;
      waddr = idx;
      wdata = fill_word;
    end else if (state == S_APPLY && item_q.req == REQ_PUT && put_wr) begin
      we    = 1'b1;
    end
    if (state == S_MOVE) begin
      re = 1'b1;
    end else if (state == S_APPLY && item_q.req == REQ_READ) begin
      re    = 1'b1;
      raddr = lin[ADDR_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      cur_col <= '0;
      cur_row <= '0;
      pend    <= 1'b0;
    end else begin
      pend <= (state == S_MOVE);
      unique case (state)
        S_IDLE: begin
          if (start) begin
            item_q.req <= item.req;
            item_q.ch  <= item.ch;
            item_q.fg  <= item.fg;
            item_q.bg  <= item.bg;
            item_q.tx  <= (item.tx > COL_W'(COLUMNS - 1)) ? COL_W'(COLUMNS - 1) : item.tx;
            item_q.ty  <= (item.ty > ROW_W'(ROWS - 1)) ? ROW_W'(ROWS - 1) : item.ty;
            cell_q     <= '0;
            scrolled_q <= 1'b0;
            state      <= S_ADDR;
          end
        end
        S_ADDR: begin
          state <= S_APPLY;
        end
        S_APPLY: begin
          unique case (item_q.req)
            REQ_PUT: begin
              cur_col <= col_a;
              cur_row <= row_a;
              if (scroll_n) begin
                scrolled_q <= 1'b1;
                fill_word  <= {fill_attr, CH_SPACE};
                idx        <= '0;
                ridx       <= ADDR_W'(COLUMNS);
                state      <= S_MOVE;
              end else begin
                state <= S_LIN;
              end
            end
            REQ_CLEAR: begin
              cur_col   <= '0;
              cur_row   <= '0;
              fill_word <= make_cell(CH_SPACE, item_q.fg, item_q.bg);
              idx       <= '0;
              state     <= S_FILL;
            end
            REQ_SET: begin
              cur_col <= item_q.tx;
              cur_row <= item_q.ty;
              state   <= S_LIN;
            end
            REQ_READ: begin
              state <= S_RWAIT;
            end
          endcase
        end
        S_RWAIT: begin
          cell_q <= rdata;
          state  <= S_LIN;
        end
        S_MOVE: begin
          // read one row down now, write it back in the next cycle
          pend_addr <= idx;
          idx       <= idx + ADDR_W'(1);
          ridx      <= ridx + ADDR_W'(1);
          if (idx == ADDR_W'(MOVE_COUNT - 1)) begin
            state <= S_FILL;
          end
        end
        S_FILL: begin
          if (!pend) begin
            if (idx == ADDR_W'(CELL_COUNT - 1)) begin
              state <= S_LIN;
            end else begin
              idx <= idx + ADDR_W'(1);
            end
          end
        end
        S_LIN: begin
          state <= S_DONE;
        end
        S_DONE: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
      endcase
    end
  end

  assign idle             = (state == S_IDLE);
  assign done             = (state == S_DONE) && out_free;
  assign result.col       = cur_col;
  assign result.row       = cur_row;
  assign result.linear    = lin[OUT_LIN_W-1:0];
  assign result.cell_word = cell_q;
  assign result.scrolled  = scrolled_q;

endmodule

// ===== sv/text_console_writer_top.sv =====
// text console writer: stream ports, fill attribute register, result register
// scroll runs a row move sweep, then a bottom row fill
// clear fills the whole screen, one cell written per cycle over the one write port
// one item at a time: s_tready is low from accept until the result is registered
// rst is synchronous: cursor homes, fill attribute 7, cell store is not cleared
module text_console_writer_top
  import tcw_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // char_code, fg_color, bg_color, target_x, target_y
  input  logic [1:0]  s_tuser,   // req_type
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata,   // cursor_col, cursor_row, cursor_linear, cell_word, did_scroll
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_data   // fill_attribute
);

  tcw_item_t         item;
  tcw_result_t       result;
  logic              idle;
  logic              done;
  logic              out_free;
  logic [ATTR_W-1:0] fill_attr;

  assign item.req = tcw_req_t'(s_tuser);
  assign item.ch  = s_tdata[7:0];
  assign item.fg  = s_tdata[11:8];
  assign item.bg  = s_tdata[15:12];
  assign item.tx  = s_tdata[22:16];
  assign item.ty  = s_tdata[27:23];

  assign s_tready  = idle;
  assign cfg_ready = 1'b1;
  assign out_free  = !m_tvalid || m_tready;

  tcw_engine u_engine (
    .clk       (clk),
    .rst       (rst),
    .start     (s_tvalid && s_tready),
    .item      (item),
    .fill_attr (fill_attr),
    .out_free  (out_free),
    .idle      (idle),
    .done      (done),
    .result    (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      fill_attr <= FILL_ATTR_RESET;
    end else if (cfg_valid && cfg_ready) begin
      fill_attr <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (done) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (done) begin
      m_tdata <= result;
    end
  end

endmodule

// ===== sv/tcw_checker.sv =====
// port-level checks for the text console writer, bound to the top level
module tcw_checker
  import tcw_pkg::*;
(
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic [31:0] s_tdata,
  input logic [1:0]  s_tuser,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [39:0] m_tdata,
  input logic        cfg_valid,
  input logic        cfg_ready,
  input logic [7:0]  cfg_data
);

  // one item in flight: no accept right after an accept
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("input accepted while an item is in flight");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
    else $error("stalled result changed");

  a_cursor_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> ((m_tdata[6:0] < COL_W'(COLUMNS)) && (m_tdata[11:7] < ROW_W'(ROWS))))
    else $error("cursor outside the screen");

  // a scroll always leaves the cursor at the start of the bottom row
  a_scroll_pos: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tdata[39]) |-> ((m_tdata[11:7] == ROW_W'(ROWS - 1)) &&
                                   (m_tdata[6:0] == '0)))
    else $error("scroll left cursor off the bottom row start");

  // cell word is only reported for a read, which never scrolls
  a_scroll_no_cell: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tdata[39]) |-> (m_tdata[38:23] == '0))
    else $error("scroll result carries a cell word");

endmodule

bind text_console_writer_top tcw_checker u_tcw_checker (.*);
